/* src/fit_mode_arena_allocator_defines.svh */
// assertion helpers used by the allocator module
`ifndef FIT_MODE_ARENA_ALLOCATOR_DEFINES_SVH
`define FIT_MODE_ARENA_ALLOCATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FMAA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define FMAA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/fmaa_pkg.sv */
// ----------------------------------------------------------------------------
// fmaa_pkg
// shared codes and field widths of the arena allocator
// ----------------------------------------------------------------------------
package fmaa_pkg;

	localparam int OFF_W  = 16;
	localparam int SIZE_W = 17;
	localparam int SUM_W  = 20;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 56;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic REG_FIT_POLICY  = 1'b0;
	localparam logic REG_ARENA_BYTES = 1'b1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

/* src/fit_mode_arena_allocator.sv */
// ----------------------------------------------------------------------------
// fit_mode_arena_allocator
// arena allocator over an address-sorted block table, first/best/worst fit
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tdata: element_bytes, element_count, free_offset; tuser: func
// m_axis    out        tdata: status, data_offset, granted_bytes, avail_bytes
// cfg       in         write enable, register index, write data
//
// an allocate multiplies, scans the table and then shifts entries up; a free scans and
// then shifts entries down; the table ram has one read port, one entry read per cycle.
// a full-table allocate skips the scan and goes straight to the response with status full.
// s_tready is high only in idle; a stalled result holds in the output register.
// reset and arena writes empty the table at once, no clearing pass.
module fit_mode_arena_allocator #(
	parameter int MAX_BLOCKS      = 64,
	parameter int HEADER_BYTES    = 32,
	parameter int ARENA_MAX_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// element_bytes[16:0], element_count[33:17], free_offset[49:34], zero pad
	input  logic [fmaa_pkg::S_TDATA_W-1:0] s_tdata,
	// func[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], data_offset[17:2], granted_bytes[34:18], avail_bytes[51:35], pad
	output logic [fmaa_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [fmaa_pkg::SIZE_W-1:0] cfg_wdata
);

`include "fit_mode_arena_allocator_defines.svh"

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int SW = fmaa_pkg::SIZE_W;
	localparam int W  = fmaa_pkg::SUM_W;
	localparam int DW = 2 * SW;
	localparam logic [W-1:0]  HDR  = W'(HEADER_BYTES);
	localparam logic [24:0]   AMAX = 25'(ARENA_MAX_BYTES);
	localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

	typedef enum logic [3:0] {
		IDLE, MULT, NEED, SCAN, LAST, PICK, SHUP, PUT, SHDN, RESP
	} state_t;

	state_t state_q;
	logic [1:0]    fit_q;
	logic [SW-1:0] arena_q, free_total_q;
	logic [CW-1:0] count_q, issue_q, sh_q;
	logic          func_q;
	logic [SW-1:0] eb_q, ec_q;
	logic [fmaa_pkg::OFF_W-1:0] fo_q;
	logic [2*SW-1:0] prod_q;
	logic [W-1:0]  need_q, prev_end_q, best_gap_q, best_left_q;
	logic          big_q, found_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] gidx_q;
	logic [SW-1:0] grant_q;
	logic [1:0]    status_q;
	logic [fmaa_pkg::OFF_W-1:0] doff_q;
	logic          v_s1, wv_s1;
	logic [IW-1:0] wdst_s1;
	logic          m_tvalid_q;
	logic [fmaa_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	logic [SW-1:0] arena_eff, cfg_arena;
	logic [SW-1:0] ent_start, ent_data;
	logic [W-1:0]  right_c, gap_c, end_c, left_over;
	logic          fits_c, take_c, match_c;
	logic [CW-1:0] sh_m1;

	fmaa_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_comb begin
		arena_eff = ({8'b0, arena_q} > AMAX) ? AMAX[SW-1:0] : arena_q;
		cfg_arena = ({8'b0, cfg_wdata} > AMAX) ? AMAX[SW-1:0] : cfg_wdata;
		ent_start = ram_rdata[DW-1:SW];
		ent_data  = ram_rdata[SW-1:0];
		right_c   = (state_q == LAST) ? W'(arena_eff) : W'(ent_start);
		gap_c     = (right_c >= prev_end_q) ? right_c - prev_end_q : '0;
		end_c     = W'(ent_start) + HDR + W'(ent_data);
		fits_c    = !big_q && (gap_c >= need_q);
		take_c    = fits_c && (!found_q ||
			(fit_q == fmaa_pkg::FIT_BEST && gap_c < best_gap_q) ||
			(fit_q == fmaa_pkg::FIT_WORST && gap_c > best_gap_q));
		match_c   = (ent_start[fmaa_pkg::OFF_W-1:0] + HDR[fmaa_pkg::OFF_W-1:0]) == fo_q;
		left_over = best_gap_q - need_q;
		sh_m1     = sh_q - CW'(1);

		ram_raddr = issue_q[IW-1:0];
		if (state_q == SHUP) begin
			ram_raddr = sh_m1[IW-1:0];
		end else if (state_q == SHDN) begin
			ram_raddr = sh_q[IW-1:0];
		end
		ram_we    = wv_s1;
		ram_waddr = wdst_s1;
		ram_wdata = ram_rdata;
		if (state_q == PUT) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = {best_left_q[SW-1:0], grant_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			fit_q        <= fmaa_pkg::FIT_FIRST;
			arena_q      <= SW'(65536);
			free_total_q <= ((25'(65536)) > AMAX) ? AMAX[SW-1:0] : SW'(65536);
			count_q      <= '0;
			v_s1         <= 1'b0;
			wv_s1        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != RESP) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_addr == fmaa_pkg::REG_FIT_POLICY) begin
					fit_q <= cfg_wdata[1:0];
				end else begin
					arena_q      <= cfg_wdata;
					count_q      <= '0;
					free_total_q <= cfg_arena;
				end
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						func_q     <= s_tuser;
						eb_q       <= s_tdata[SW-1:0];
						ec_q       <= s_tdata[2*SW-1:SW];
						fo_q       <= s_tdata[2*SW+fmaa_pkg::OFF_W-1:2*SW];
						found_q    <= 1'b0;
						issue_q    <= '0;
						prev_end_q <= '0;
						grant_q    <= '0;
						doff_q     <= '0;
						status_q   <= fmaa_pkg::ST_OK;
						if (s_tuser == fmaa_pkg::FUNC_FREE) begin
							state_q <= SCAN;
						end else if (count_q >= MAXB) begin
							status_q <= fmaa_pkg::ST_FULL;
							state_q  <= RESP;
						end else begin
							state_q <= MULT;
						end
					end
				end
				MULT: begin
					prod_q  <= eb_q * ec_q;
					state_q <= NEED;
				end
				NEED: begin
					big_q   <= |prod_q[2*SW-1:W-2];
					need_q  <= W'(prod_q[W-3:0]) + HDR;
					state_q <= SCAN;
				end
				SCAN: begin
					if (issue_q < count_q) begin
						v_s1    <= 1'b1;
						issue_q <= issue_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (func_q == fmaa_pkg::FUNC_FREE) begin
							if (!found_q && match_c) begin
								found_q <= 1'b1;
								pos_q   <= gidx_q[IW-1:0];
								grant_q <= ent_data;
							end
						end else begin
							if (take_c) begin
								found_q     <= 1'b1;
								pos_q       <= gidx_q[IW-1:0];
								best_gap_q  <= gap_c;
								best_left_q <= prev_end_q;
							end
							prev_end_q <= end_c;
						end
					end
					gidx_q <= issue_q;
					if (!(issue_q < count_q) && !v_s1) begin
						state_q <= (func_q == fmaa_pkg::FUNC_FREE) ? PICK : LAST;
					end
				end
				LAST: begin
					// gap between the last block and the arena end
					if (take_c) begin
						found_q     <= 1'b1;
						pos_q       <= count_q[IW-1:0];
						best_gap_q  <= gap_c;
						best_left_q <= prev_end_q;
					end
					state_q <= PICK;
				end
				PICK: begin
					if (!found_q) begin
						status_q <= (func_q == fmaa_pkg::FUNC_FREE) ?
							fmaa_pkg::ST_BADFREE : fmaa_pkg::ST_NOSPACE;
						grant_q  <= '0;
						state_q  <= RESP;
					end else if (func_q == fmaa_pkg::FUNC_FREE) begin
						free_total_q <= SW'(W'(free_total_q) + HDR + W'(grant_q));
						sh_q         <= CW'(pos_q) + CW'(1);
						state_q      <= SHDN;
					end else begin
						doff_q <= fmaa_pkg::OFF_W'(best_left_q + HDR);
						// leftover smaller than a header is absorbed
						if (left_over < HDR) begin
							grant_q      <= SW'(best_gap_q - HDR);
							free_total_q <= (W'(free_total_q) >= best_gap_q) ?
								SW'(W'(free_total_q) - best_gap_q) : '0;
						end else begin
							grant_q      <= prod_q[SW-1:0];
							free_total_q <= (W'(free_total_q) >= need_q) ?
								SW'(W'(free_total_q) - need_q) : '0;
						end
						sh_q    <= count_q;
						state_q <= SHUP;
					end
				end
				SHUP: begin
					if (sh_q > CW'(pos_q)) begin
						wv_s1   <= 1'b1;
						wdst_s1 <= sh_q[IW-1:0];
						sh_q    <= sh_m1;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							state_q <= PUT;
						end
					end
				end
				PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= RESP;
				end
				SHDN: begin
					if (sh_q < count_q) begin
						wv_s1   <= 1'b1;
						wdst_s1 <= sh_m1[IW-1:0];
						sh_q    <= sh_q + CW'(1);
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= RESP;
						end
					end
				end
				RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, free_total_q, grant_q, doff_q, status_q};
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`FMAA_ASSERT_ALWAYS(a_count_bound, count_q <= MAXB, "block count above table depth")
	`FMAA_ASSERT_ALWAYS(a_idle_quiet, (state_q != IDLE) || (!v_s1 && !wv_s1),
		"table access pending while idle")
	`FMAA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"new word taken while previous one in progress")

endmodule

/* src/fmaa_ram.sv */
// ----------------------------------------------------------------------------
// fmaa_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module fmaa_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
